// ----- sv/tclm_pkg.sv -----
// ----------------------------------------------------------------------------
// tclm_pkg: shared types and constants for the two-channel LED mix block
// Holds the controller-to-datapath command word and the fixed arithmetic
// constants used by the percent scaling.
// ----------------------------------------------------------------------------
package tclm_pkg;

  // Percent ceiling and rounding offset
  localparam logic [6:0]  PCT_MAX      = 7'd100;
  localparam logic [13:0] ROUND_HALF   = 14'd50;

  // x / 100 == (x * 5243) >> 19 for every x up to 10050
  localparam logic [12:0] RECIP_100    = 13'd5243;
  localparam int          RECIP_SHIFT  = 19;

  // Register indexes of the configuration port
  localparam logic [1:0]  CFG_CEILING  = 2'd0;
  localparam logic [1:0]  CFG_STEP     = 2'd1;

  // Register reset values
  localparam logic [6:0]  CEILING_RST  = 7'd50;
  localparam logic [6:0]  STEP_RST     = 7'd2;

  // One command per datapath stage; the controller asserts one at a time
  typedef struct packed {
    logic load;     // capture and clamp the input word
    logic mul_tot;  // brightness * ceiling + 50
    logic div_tot;  // total duty = product / 100
    logic mul_mix;  // total * mix shares + 50
    logic div_mix;  // channel targets = products / 100
    logic fix;      // trim rounding excess or shortfall onto the larger target
    logic commit;   // slew both levels toward their targets
  } cmd_t;

endpackage

// ----- sv/two_channel_led_mix_with_ramp_core.sv -----
// ----------------------------------------------------------------------------
// two_channel_led_mix_with_ramp_core: warm/cool LED duty mixer with slew limit
// Each word is accepted in idle and then steps through a six-stage sequence:
// multiply, divide-by-100, multiply, divide-by-100, trim and commit. Commit
// waits for the result slot to be free; no new word is accepted until idle.
// Reset (rst_n low, synchronous): ceiling 50, step 2, both levels 0, idle.
// ----------------------------------------------------------------------------
module two_channel_led_mix_with_ramp_core (
  input  logic       clk,
  input  logic       rst_n,
  // configuration write port
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [6:0] cfg_wdata,
  // update words in
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_brightness_level,
  input  logic [7:0] in_colour_mix,
  // duty words out
  output logic       out_valid,
  input  logic       out_stall,
  output logic [6:0] out_warm_duty,
  output logic [6:0] out_cool_duty
);

  // Command word from sequencer to datapath, one stage strobe at a time
  tclm_pkg::cmd_t cmd;

  // Sequencer: accept a word, advance through the stages, commit the new
  // levels only once the output slot is free, then return to idle.
  tclm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // Datapath: the channel level registers double as the output word, since
  // they change only on commit, which waits for the previous word to drain.
  tclm_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_brightness_level (in_brightness_level),
    .in_colour_mix       (in_colour_mix),
    .warm_level          (out_warm_duty),
    .cool_level          (out_cool_duty)
  );

endmodule

// ----- sv/tclm_dp.sv -----
// ----------------------------------------------------------------------------
// tclm_dp: datapath of the two-channel LED mix block
// Configuration registers, scaling multipliers, divide-by-100 reciprocal
// stage, rounding trim and slew limiter for the two channel levels.
// ----------------------------------------------------------------------------
module tclm_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  tclm_pkg::cmd_t    cmd,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [6:0]        cfg_wdata,
  input  logic [7:0]        in_brightness_level,
  input  logic [7:0]        in_colour_mix,
  output logic [6:0]        warm_level,
  output logic [6:0]        cool_level
);

  logic [6:0]  ceiling_r;
  logic [6:0]  step_r;
  logic [6:0]  bright_r;
  logic [6:0]  mix_r;
  logic [13:0] prod_r;
  logic [6:0]  total_r;
  logic [13:0] warm_prod_r;
  logic [13:0] cool_prod_r;
  logic [6:0]  warm_tgt_r;
  logic [6:0]  cool_tgt_r;
  logic [6:0]  warm_lvl_r;
  logic [6:0]  cool_lvl_r;

  logic [6:0]  ceil_eff;
  logic [6:0]  step_eff;
  logic [7:0]  tgt_sum;
  logic [6:0]  warm_fix;
  logic [6:0]  cool_fix;
  logic [6:0]  warm_lvl_nxt;
  logic [6:0]  cool_lvl_nxt;

  function automatic logic [6:0] clamp_pct(input logic [7:0] v);
    clamp_pct = (v > {1'b0, tclm_pkg::PCT_MAX}) ? tclm_pkg::PCT_MAX : v[6:0];
  endfunction

  function automatic logic [6:0] div100(input logic [13:0] x);
    logic [26:0] q;
    q = 27'(x) * 27'(tclm_pkg::RECIP_100);
    div100 = q[tclm_pkg::RECIP_SHIFT +: 7];
  endfunction

  function automatic logic [6:0] slew(input logic [6:0] cur, input logic [6:0] tgt,
                                     input logic [6:0] step);
    logic [7:0] up;
    logic [6:0] gap;
    up  = {1'b0, cur} + {1'b0, step};
    gap = cur - tgt;
    if (tgt > cur) begin
      slew = (up > {1'b0, tgt}) ? tgt : up[6:0];
    end else if (tgt < cur) begin
      slew = (gap <= step) ? tgt : cur - step;
    end else begin
      slew = cur;
    end
  endfunction

  assign ceil_eff = clamp_pct({1'b0, ceiling_r});
  assign step_eff = (step_r == 7'd0) ? 7'd1 : clamp_pct({1'b0, step_r});

  // Trim the rounding excess or shortfall onto the larger target, cool on a tie
  assign tgt_sum = {1'b0, warm_tgt_r} + {1'b0, cool_tgt_r};
  always_comb begin
    logic [7:0] tot8;
    logic [6:0] d;
    tot8     = {1'b0, total_r};
    warm_fix = warm_tgt_r;
    cool_fix = cool_tgt_r;
    d        = 7'd0;
    if (tgt_sum < tot8) begin
      d = 7'(tot8 - tgt_sum);
      if (warm_tgt_r > cool_tgt_r) warm_fix = warm_tgt_r + d;
      else                         cool_fix = cool_tgt_r + d;
    end else if (tgt_sum > tot8) begin
      d = 7'(tgt_sum - tot8);
      if (warm_tgt_r > cool_tgt_r) warm_fix = (warm_tgt_r > d) ? warm_tgt_r - d : 7'd0;
      else                         cool_fix = (cool_tgt_r > d) ? cool_tgt_r - d : 7'd0;
    end
  end

  assign warm_lvl_nxt = slew(warm_lvl_r, warm_tgt_r, step_eff);
  assign cool_lvl_nxt = slew(cool_lvl_r, cool_tgt_r, step_eff);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ceiling_r  <= tclm_pkg::CEILING_RST;
      step_r     <= tclm_pkg::STEP_RST;
      warm_lvl_r <= 7'd0;
      cool_lvl_r <= 7'd0;
    end else begin
      if (cfg_we && cfg_index == tclm_pkg::CFG_CEILING) ceiling_r <= cfg_wdata;
      if (cfg_we && cfg_index == tclm_pkg::CFG_STEP)    step_r    <= cfg_wdata;
      if (cmd.commit) begin
        warm_lvl_r <= warm_lvl_nxt;
        cool_lvl_r <= cool_lvl_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bright_r <= clamp_pct(in_brightness_level);
      mix_r    <= clamp_pct(in_colour_mix);
    end
    if (cmd.mul_tot) prod_r  <= 14'(bright_r * ceil_eff) + tclm_pkg::ROUND_HALF;
    if (cmd.div_tot) total_r <= div100(prod_r);
    if (cmd.mul_mix) begin
      warm_prod_r <= 14'(total_r * (tclm_pkg::PCT_MAX - mix_r)) + tclm_pkg::ROUND_HALF;
      cool_prod_r <= 14'(total_r * mix_r) + tclm_pkg::ROUND_HALF;
    end
    if (cmd.div_mix) begin
      warm_tgt_r <= div100(warm_prod_r);
      cool_tgt_r <= div100(cool_prod_r);
    end else if (cmd.fix) begin
      warm_tgt_r <= warm_fix;
      cool_tgt_r <= cool_fix;
    end
  end

  assign warm_level = warm_lvl_r;
  assign cool_level = cool_lvl_r;

endmodule

// ----- sv/tclm_ctrl.sv -----
// ----------------------------------------------------------------------------
// tclm_ctrl: sequencer of the two-channel LED mix block
// Steps one word through the datapath stages and owns the result valid.
// ----------------------------------------------------------------------------
module tclm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output tclm_pkg::cmd_t    cmd
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_MUL_TOT = 3'd1;
  localparam logic [2:0] S_DIV_TOT = 3'd2;
  localparam logic [2:0] S_MUL_MIX = 3'd3;
  localparam logic [2:0] S_DIV_MIX = 3'd4;
  localparam logic [2:0] S_FIX     = 3'd5;
  localparam logic [2:0] S_SLEW    = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  // Result slot is free when empty or being drained this cycle
  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_MUL_TOT;
        end
      end
      S_MUL_TOT: begin cmd.mul_tot = 1'b1; state_nxt = S_DIV_TOT; end
      S_DIV_TOT: begin cmd.div_tot = 1'b1; state_nxt = S_MUL_MIX; end
      S_MUL_MIX: begin cmd.mul_mix = 1'b1; state_nxt = S_DIV_MIX; end
      S_DIV_MIX: begin cmd.div_mix = 1'b1; state_nxt = S_FIX;     end
      S_FIX:     begin cmd.fix     = 1'b1; state_nxt = S_SLEW;    end
      S_SLEW: begin
        // hold until the previous result has left
        if (slot_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.commit) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule
